// File: hw/rtl/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// shared widths, codes, reset values and record types of the blob tracker
// ----------------------------------------------------------------------------
package bct_pkg;

  // field widths
  localparam int AREA_W     = 24;
  localparam int POS_W      = 16;
  localparam int ID_W       = 16;
  localparam int DIST_W     = 12;
  localparam int EDGE_W     = 12;
  localparam int STATUS_W   = 3;
  localparam int TOTAL_W    = 32;
  localparam int COUNT_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int LIMIT_W    = 2 * DIST_W;

  // parameter defaults
  localparam int DEF_TABLE_SLOTS = 64;
  localparam int DEF_FRAC_BITS   = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AREA       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DISTANCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EDGE_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_EDGE_X   = 3'd4;

  // register reset values
  localparam logic [AREA_W-1:0] RST_MIN_AREA       = 24'd40;
  localparam logic [AREA_W-1:0] RST_MAX_AREA       = 24'd40000;
  localparam logic [DIST_W-1:0] RST_MATCH_DISTANCE = 12'd320;
  localparam logic [EDGE_W-1:0] RST_LEFT_EDGE_X    = 12'd0;
  localparam logic [EDGE_W-1:0] RST_RIGHT_EDGE_X   = 12'd0;

  // commands
  localparam logic CMD_BLOB      = 1'b0;
  localparam logic CMD_FRAME_END = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_IGNORED   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_MATCHED   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_NEW       = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FRAME_END = 3'd4;

  // divide by three: floor(n * RECIP3 >> RECIP3_SHIFT) is exact for n < 2^15
  localparam int RECIP3       = 21846;
  localparam int RECIP3_SHIFT = 16;

  // one table entry as kept in memory
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             counted;
  } slot_t;

  // one result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     object_id;
    logic                counted_now;
    logic [AREA_W-1:0]   counted_area;
    logic [TOTAL_W-1:0]  frame_area_total;
    logic [COUNT_W-1:0]  frame_count;
  } result_t;

endpackage

// File: hw/rtl/blob_centroid_tracker_counter.sv
// ----------------------------------------------------------------------------
// blob_centroid_tracker_counter
// centroid tracker with a counting zone between two vertical edges
// ----------------------------------------------------------------------------
// Blob reports (centroid in 12.4 fixed point pixels, area in half pixels) and
// end-of-frame marks arrive on the in channel; each one produces exactly one
// result on the out channel. A blob whose area is zero or outside
// [min_area, max_area] is ignored. A kept blob is compared against every live
// table entry: the entry with the smallest squared distance below
// match_distance squared wins (ties to the lower id), otherwise the blob takes
// the lowest free entry and a fresh id, or is reported as table full. A blob
// is counted once, the first time its x lies in the middle third between
// left_edge_x and right_edge_x. An end-of-frame mark drops entries not seen in
// the frame and reports the frame's saturating area total and count. Entry
// records live in one ram with one read port that is scanned one entry per
// cycle, so a kept blob raises its result only after the scan has read every
// entry, the three-stage compare pipeline has emptied, the decision step has
// run and the result state has loaded the output register; ignored blobs and
// frame ends go from the transfer in straight to the result state. A new item
// is taken while the previous result still waits on the out channel.
// Configuration writes must only be issued while no item is in flight.
module blob_centroid_tracker_counter #(
  parameter int TABLE_SLOTS = bct_pkg::DEF_TABLE_SLOTS,
  parameter int FRAC_BITS   = bct_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [bct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bct_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [bct_pkg::POS_W-1:0]         centroid_x,
  input  logic [bct_pkg::POS_W-1:0]         centroid_y,
  input  logic [bct_pkg::AREA_W-1:0]        blob_area,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bct_pkg::STATUS_W-1:0]      status,
  output logic [bct_pkg::ID_W-1:0]          object_id,
  output logic                              counted_now,
  output logic [bct_pkg::AREA_W-1:0]        counted_area,
  output logic [bct_pkg::TOTAL_W-1:0]       frame_area_total,
  output logic [bct_pkg::COUNT_W-1:0]       frame_count
);

  import bct_pkg::*;

  localparam int IW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int ZW   = EDGE_W + 1 + FRAC_BITS;  // zone bound in 1/16 pixel
  localparam int CW   = (ZW > POS_W) ? ZW : POS_W;
  localparam int SQ_W = 2 * POS_W;
  localparam int D_W  = SQ_W + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_DECIDE = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state;

  // configuration registers
  logic [AREA_W-1:0] min_area, max_area;
  logic [DIST_W-1:0] match_distance;
  logic [EDGE_W-1:0] left_edge_x, right_edge_x;

  // derived from configuration, refreshed every cycle
  logic [LIMIT_W-1:0] lim;
  logic               edge_fwd;
  logic [EDGE_W-1:0]  zone_q1, zone_q2;
  logic [EDGE_W-1:0]  edge_span;
  logic [EDGE_W+14:0] prod1;
  logic [EDGE_W+15:0] prod2;

  // per-entry flags, cleared at reset
  logic [TABLE_SLOTS-1:0] slot_valid, slot_seen;

  // frame and id state
  logic [ID_W-1:0]    next_id;
  logic [TOTAL_W-1:0] area_sum;
  logic [COUNT_W-1:0] count_sum;

  // item in flight
  logic [POS_W-1:0]  rq_cx, rq_cy;
  logic [AREA_W-1:0] rq_area;

  // scan pipeline
  logic [IW-1:0]      rd_idx;
  logic               v_a, v_b, v_c;
  logic [IW-1:0]      a_idx, b_idx, c_idx;
  logic               a_sv, b_sv, c_sv;
  logic [ID_W-1:0]    b_id, c_id;
  logic               b_cnt, c_cnt;
  logic [POS_W-1:0]   bx, by;
  logic [SQ_W-1:0]    sqx, sqy;
  logic [D_W-1:0]     c_d;
  logic               c_take;

  // best match and first free entry
  logic               best_found, free_found;
  logic [IW-1:0]      best_idx, free_idx;
  logic [D_W-1:0]     best_d;
  logic [ID_W-1:0]    best_id;
  logic               best_cnt;

  // decision
  logic               dec_place;
  logic [IW-1:0]      dec_idx;
  logic [ID_W-1:0]    dec_id;
  logic               dec_cnt_prev;
  logic               dec_count;
  logic [TOTAL_W:0]   sum_ext;
  logic [EDGE_W:0]    zs, ze;
  logic [CW-1:0]      zlo, zhi, cx_ext;
  logic               in_zone;
  logic               area_bad;
  logic               accept;

  // memory
  slot_t              ram_rdata, ram_wdata;
  logic               ram_we, ram_re;

  result_t            res;
  result_t            acc_res, dec_res;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign area_bad = (blob_area == '0) || (blob_area < min_area) || (blob_area > max_area);

  // ---- configuration derived values ----
  // |R - L| split into thirds by reciprocal multiply
  assign edge_span = (right_edge_x >= left_edge_x) ? (right_edge_x - left_edge_x)
                                                   : (left_edge_x - right_edge_x);
  assign prod1 = (EDGE_W + 15)'(edge_span) * (EDGE_W + 15)'(RECIP3);
  assign prod2 = (EDGE_W + 16)'({edge_span, 1'b0}) * (EDGE_W + 16)'(RECIP3);

  always_ff @(posedge clk) begin
    lim      <= LIMIT_W'(match_distance) * LIMIT_W'(match_distance);
    edge_fwd <= (right_edge_x >= left_edge_x);
    zone_q1  <= EDGE_W'(prod1 >> RECIP3_SHIFT);
    zone_q2  <= EDGE_W'(prod2 >> RECIP3_SHIFT);
  end

  // zone bounds in whole pixels; a reversed span gives zs above ze
  assign zs = edge_fwd ? ({1'b0, left_edge_x} + {1'b0, zone_q1})
                       : ({1'b0, left_edge_x} - {1'b0, zone_q1});
  assign ze = edge_fwd ? ({1'b0, left_edge_x} + {1'b0, zone_q2})
                       : ({1'b0, left_edge_x} - {1'b0, zone_q2});
  assign zlo    = CW'(zs) << FRAC_BITS;
  assign zhi    = CW'(ze) << FRAC_BITS;
  assign cx_ext = CW'(rq_cx);
  assign in_zone = (cx_ext >= zlo) && (cx_ext <= zhi);

  // ---- entry memory ----
  assign ram_re = (state == S_SCAN);

  bct_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dec_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // ---- scan datapath ----
  // stage a: ram data arrives, take absolute differences
  // stage b: square both differences
  // stage c: sum and compare against the limit and the best so far
  always_ff @(posedge clk) begin
    a_idx <= rd_idx;
    a_sv  <= slot_valid[rd_idx];

    b_idx <= a_idx;
    b_sv  <= a_sv;
    b_id  <= ram_rdata.id;
    b_cnt <= ram_rdata.counted;
    bx    <= (ram_rdata.pos_x >= rq_cx) ? (ram_rdata.pos_x - rq_cx) : (rq_cx - ram_rdata.pos_x);
    by    <= (ram_rdata.pos_y >= rq_cy) ? (ram_rdata.pos_y - rq_cy) : (rq_cy - ram_rdata.pos_y);

    c_idx <= b_idx;
    c_sv  <= b_sv;
    c_id  <= b_id;
    c_cnt <= b_cnt;
    sqx   <= SQ_W'(bx) * SQ_W'(bx);
    sqy   <= SQ_W'(by) * SQ_W'(by);
  end

  assign c_d    = {1'b0, sqx} + {1'b0, sqy};
  assign c_take = v_c && c_sv && (c_d < D_W'(lim)) &&
                  (!best_found || (c_d < best_d) || ((c_d == best_d) && (c_id < best_id)));

  // ---- decision ----
  always_comb begin
    dec_place    = best_found || free_found;
    dec_idx      = best_found ? best_idx : free_idx;
    dec_id       = best_found ? best_id : next_id;
    dec_cnt_prev = best_found ? best_cnt : 1'b0;
    dec_count    = dec_place && in_zone && !dec_cnt_prev;
    sum_ext      = {1'b0, area_sum} + (TOTAL_W + 1)'(rq_area);
  end

  // result of a kept blob
  always_comb begin
    dec_res = '0;
    if (best_found) begin
      dec_res.status = STAT_MATCHED;
    end else if (free_found) begin
      dec_res.status = STAT_NEW;
    end else begin
      dec_res.status = STAT_FULL;
    end
    if (dec_place) begin
      dec_res.object_id = dec_id;
    end
    if (dec_count) begin
      dec_res.counted_now  = 1'b1;
      dec_res.counted_area = rq_area;
    end
  end

  // result of a frame end or an ignored blob, known at the transfer in
  always_comb begin
    acc_res = '0;
    if (cmd == CMD_FRAME_END) begin
      acc_res.status           = STAT_FRAME_END;
      acc_res.frame_area_total = area_sum;
      acc_res.frame_count      = count_sum;
    end else begin
      acc_res.status = STAT_IGNORED;
    end
  end

  assign ram_we            = (state == S_DECIDE) && dec_place;
  assign ram_wdata.id      = dec_id;
  assign ram_wdata.pos_x   = rq_cx;
  assign ram_wdata.pos_y   = rq_cy;
  assign ram_wdata.counted = dec_cnt_prev || dec_count;

  // ---- control ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      min_area       <= RST_MIN_AREA;
      max_area       <= RST_MAX_AREA;
      match_distance <= RST_MATCH_DISTANCE;
      left_edge_x    <= RST_LEFT_EDGE_X;
      right_edge_x   <= RST_RIGHT_EDGE_X;
      slot_valid     <= '0;
      slot_seen      <= '0;
      next_id        <= '0;
      area_sum       <= '0;
      count_sum      <= '0;
      v_a            <= 1'b0;
      v_b            <= 1'b0;
      v_c            <= 1'b0;
      best_found     <= 1'b0;
      free_found     <= 1'b0;
    end else begin
      v_a <= (state == S_SCAN);
      v_b <= v_a;
      v_c <= v_b;

      // the result state reloads the output itself
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_AREA:       min_area       <= cfg_data[AREA_W-1:0];
          CFG_MAX_AREA:       max_area       <= cfg_data[AREA_W-1:0];
          CFG_MATCH_DISTANCE: match_distance <= cfg_data[DIST_W-1:0];
          CFG_LEFT_EDGE_X:    left_edge_x    <= cfg_data[EDGE_W-1:0];
          CFG_RIGHT_EDGE_X:   right_edge_x   <= cfg_data[EDGE_W-1:0];
          default: ;
        endcase
      end

      if (c_take) begin
        best_found <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == CMD_FRAME_END) begin
              // drop unseen entries, start the next frame
              slot_valid <= slot_valid & slot_seen;
              slot_seen  <= '0;
              area_sum   <= '0;
              count_sum  <= '0;
              state      <= S_RESP;
            end else if (area_bad) begin
              state <= S_RESP;
            end else begin
              best_found <= 1'b0;
              free_found <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!slot_valid[rd_idx]) begin
            free_found <= 1'b1;
          end
          if (rd_idx == LAST_IDX) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v_a && !v_b && !v_c) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (dec_place) begin
            slot_seen[dec_idx] <= 1'b1;
          end
          if (!best_found && free_found) begin
            slot_valid[dec_idx] <= 1'b1;
            next_id             <= next_id + ID_W'(1);
          end
          if (dec_count) begin
            area_sum <= sum_ext[TOTAL_W] ? '1 : sum_ext[TOTAL_W-1:0];
            if (count_sum != '1) begin
              count_sum <= count_sum + COUNT_W'(1);
            end
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (accept) begin
      rq_cx   <= centroid_x;
      rq_cy   <= centroid_y;
      rq_area <= blob_area;
      rd_idx  <= '0;
      res     <= acc_res;
    end

    if (state == S_SCAN) begin
      // first free entry in index order
      if (!slot_valid[rd_idx] && !free_found) begin
        free_idx <= rd_idx;
      end
      if (rd_idx != LAST_IDX) begin
        rd_idx <= rd_idx + IW'(1);
      end
    end

    if (c_take) begin
      best_idx <= c_idx;
      best_d   <= c_d;
      best_id  <= c_id;
      best_cnt <= c_cnt;
    end

    if (state == S_DECIDE) begin
      res <= dec_res;
    end

    if ((state == S_RESP) && (!out_valid || out_ready)) begin
      status           <= res.status;
      object_id        <= res.object_id;
      counted_now      <= res.counted_now;
      counted_area     <= res.counted_area;
      frame_area_total <= res.frame_area_total;
      frame_count      <= res.frame_count;
    end
  end

  // ---- assertions ----
  // a seen mark only ever sits on a live entry
  a_seen_is_valid: assert property (@(posedge clk) disable iff (rst)
    (slot_seen & ~slot_valid) == '0)
    else $error("seen mark on a free entry");

  // a frame end leaves no seen marks behind
  a_frame_clears_seen: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_FRAME_END)) |=> (slot_seen == '0))
    else $error("seen marks survive a frame end");

  // the scan pipeline is empty whenever a new item can come in
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(v_a || v_b || v_c))
    else $error("scan pipeline busy while idle");

  // memory is written only at the decision step
  a_write_in_decide: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_DECIDE))
    else $error("entry memory written outside the decision step");

  // a result appears only when leaving the result state
  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESP))
    else $error("result raised outside the result state");

endmodule

// File: hw/rtl/bct_ram.sv
// ----------------------------------------------------------------------------
// bct_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module bct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: bench/blob_centroid_tracker_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blob_centroid_tracker_counter_tb
// self-checking bench for the blob centroid tracker with counting zone
// ----------------------------------------------------------------------------
// A queue of blob reports and end-of-frame marks feeds a valid/ready driver.
// Each transfer in is run through a behavioral tracker kept in the bench,
// which holds its own copy of the object table, the id counter, the frame sums
// and the register settings. The result it predicts is queued, and a monitor
// compares every result transfer against the oldest prediction. Stimulus is a
// short directed set, then tracked-object scenarios (objects drifting across
// the counting zone frame after frame, with dropouts, noise blobs and crowds
// that fill the table) under a series of register settings. Both channels
// idle at random. Registers are only changed once every result is back.
// ----------------------------------------------------------------------------
module blob_centroid_tracker_counter_tb;
  import bct_pkg::*;

  localparam int SLOTS          = DEF_TABLE_SLOTS;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TARGET_ITEMS   = 1250;
  localparam int MAX_OBJ        = 70;
  localparam int unsigned AREA_MAX = 32'h00FF_FFFF;

  typedef struct {
    logic              c;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [AREA_W-1:0] a;
  } blob_item_t;

  // dut connections, all inputs known from time zero
  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_MIN_AREA;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic                  cmd        = CMD_BLOB;
  logic [POS_W-1:0]      centroid_x = '0;
  logic [POS_W-1:0]      centroid_y = '0;
  logic [AREA_W-1:0]     blob_area  = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [ID_W-1:0]       object_id;
  logic                  counted_now;
  logic [AREA_W-1:0]     counted_area;
  logic [TOTAL_W-1:0]    frame_area_total;
  logic [COUNT_W-1:0]    frame_count;

  // register shadow
  logic [AREA_W-1:0] area_lo;
  logic [AREA_W-1:0] area_hi;
  logic [DIST_W-1:0] match_dist;
  logic [EDGE_W-1:0] edge_l;
  logic [EDGE_W-1:0] edge_r;

  // tracker state mirror
  logic               trk_live    [SLOTS];
  logic [ID_W-1:0]    trk_id      [SLOTS];
  logic [POS_W-1:0]   trk_x       [SLOTS];
  logic [POS_W-1:0]   trk_y       [SLOTS];
  logic               trk_counted [SLOTS];
  logic               trk_seen    [SLOTS];
  logic [ID_W-1:0]    trk_next_id;
  logic [TOTAL_W-1:0] trk_area_sum;
  logic [COUNT_W-1:0] trk_count_sum;

  blob_item_t pending_blobs[$];
  result_t    predicted_results[$];
  int         fail_count   = 0;
  int         sent_items   = 0;
  int         idle_cycles  = 0;
  bit         in_gaps_on   = 1'b1;
  bit         out_stalls_on = 1'b1;

  blob_centroid_tracker_counter uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .centroid_x       (centroid_x),
    .centroid_y       (centroid_y),
    .blob_area        (blob_area),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .object_id        (object_id),
    .counted_now      (counted_now),
    .counted_area     (counted_area),
    .frame_area_total (frame_area_total),
    .frame_count      (frame_count)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // tracker prediction: one transfer in, one result out, state updated
  // --------------------------------------------------------------------------
  function automatic result_t track_blob(logic c, logic [POS_W-1:0] cx,
                                         logic [POS_W-1:0] cy,
                                         logic [AREA_W-1:0] area);
    result_t            r;
    int                 hit;
    int                 zs;
    int                 ze;
    logic [33:0]        dx;
    logic [33:0]        dy;
    logic [33:0]        d;
    logic [33:0]        best_d;
    logic [LIMIT_W-1:0] lim;
    logic [TOTAL_W:0]   sum;
    r   = '0;
    lim = LIMIT_W'(match_dist) * LIMIT_W'(match_dist);
    if (c == CMD_FRAME_END) begin
      // report the frame, then drop whatever was not seen in it
      r.status           = STAT_FRAME_END;
      r.frame_area_total = trk_area_sum;
      r.frame_count      = trk_count_sum;
      for (int i = 0; i < SLOTS; i++) begin
        if (!trk_seen[i]) trk_live[i] = 1'b0;
        trk_seen[i] = 1'b0;
      end
      trk_area_sum  = '0;
      trk_count_sum = '0;
      return r;
    end
    // zero area or outside the window: ignored, no state change
    if (area == '0 || area < area_lo || area > area_hi) return r;
    // nearest live object strictly inside the limit, ties to the lower id
    hit    = -1;
    best_d = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (trk_live[i]) begin
        dx = 34'((trk_x[i] > cx) ? trk_x[i] - cx : cx - trk_x[i]);
        dy = 34'((trk_y[i] > cy) ? trk_y[i] - cy : cy - trk_y[i]);
        d  = dx * dx + dy * dy;
        if (d < 34'(lim) && (hit < 0 || d < best_d ||
                             (d == best_d && trk_id[i] < trk_id[hit]))) begin
          hit    = i;
          best_d = d;
        end
      end
    end
    if (hit >= 0) begin
      r.status = STAT_MATCHED;
    end else begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!trk_live[i]) hit = i;
      end
      if (hit < 0) begin
        r.status = STAT_FULL;
        return r;
      end
      trk_live[hit]    = 1'b1;
      trk_id[hit]      = trk_next_id;
      trk_counted[hit] = 1'b0;
      trk_next_id      = trk_next_id + ID_W'(1);
      r.status         = STAT_NEW;
    end
    trk_x[hit]    = cx;
    trk_y[hit]    = cy;
    trk_seen[hit] = 1'b1;
    r.object_id   = trk_id[hit];
    // middle third of the zone, bounds truncated toward zero
    zs = int'(edge_l) + (int'(edge_r) - int'(edge_l)) / 3;
    ze = int'(edge_l) + (2 * (int'(edge_r) - int'(edge_l))) / 3;
    if (zs >= 0 && ze >= 0 && !trk_counted[hit] &&
        int'(cx) >= zs * (1 << DEF_FRAC_BITS) &&
        int'(cx) <= ze * (1 << DEF_FRAC_BITS)) begin
      trk_counted[hit] = 1'b1;
      r.counted_now    = 1'b1;
      r.counted_area   = area;
      sum = {1'b0, trk_area_sum} + (TOTAL_W + 1)'(area);
      trk_area_sum = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      if (trk_count_sum != '1) trk_count_sum = trk_count_sum + COUNT_W'(1);
    end
    return r;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_item(logic c, int x, int y, logic [AREA_W-1:0] a);
    blob_item_t it;
    it.c = c;
    it.x = x[POS_W-1:0];
    it.y = y[POS_W-1:0];
    it.a = a;
    pending_blobs.insert(pending_blobs.size(), it);
    sent_items++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
  endtask

  // only called with nothing in flight
  task automatic load_config(int unsigned mn, int unsigned mx, int unsigned md,
                             int unsigned l, int unsigned r);
    write_reg(CFG_MIN_AREA, mn);
    write_reg(CFG_MAX_AREA, mx);
    write_reg(CFG_MATCH_DISTANCE, md);
    write_reg(CFG_LEFT_EDGE_X, l);
    write_reg(CFG_RIGHT_EDGE_X, r);
    @(posedge clk);
    cfg_we     <= 1'b0;
    area_lo    = mn[AREA_W-1:0];
    area_hi    = mx[AREA_W-1:0];
    match_dist = md[DIST_W-1:0];
    edge_l     = l[EDGE_W-1:0];
    edge_r     = r[EDGE_W-1:0];
    // some phases run with one or both sides never idling
    in_gaps_on    = ($urandom_range(0, 3) != 0);
    out_stalls_on = ($urandom_range(0, 3) != 0);
  endtask

  function automatic int clamp_pos(int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // area inside the kept window when there is one
  function automatic logic [AREA_W-1:0] kept_area();
    int unsigned lo;
    int unsigned r;
    lo = (area_lo == '0) ? 1 : area_lo;
    if (lo > area_hi) return AREA_W'($urandom_range(0, AREA_MAX));
    r = $urandom_range(0, 9);
    if (r < 2) return lo[AREA_W-1:0];
    if (r < 4) return area_hi;
    return AREA_W'($urandom_range(lo, area_hi));
  endfunction

  function automatic logic [AREA_W-1:0] noise_area();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return (area_lo == '0) ? '0 : area_lo - 1'b1;
      2: return (area_hi == '1) ? area_hi : area_hi + 1'b1;
      3: return AREA_W'($urandom_range(0, AREA_MAX));
      4: return '1;
      default: return kept_area();
    endcase
  endfunction

  // objects drifting over several frames, with dropouts and noise blobs
  task automatic gen_frames(int frames, int n_obj, int speed, int x_lo, int x_hi);
    int ox[MAX_OBJ];
    int oy[MAX_OBJ];
    int vx[MAX_OBJ];
    int vy[MAX_OBJ];
    int first;
    int k;
    for (int i = 0; i < n_obj; i++) begin
      ox[i] = $urandom_range(x_lo, x_hi);
      oy[i] = $urandom_range(0, 65535);
      vx[i] = int'($urandom_range(0, 2 * speed)) - speed;
      vy[i] = int'($urandom_range(0, 2 * speed)) - speed;
    end
    for (int f = 0; f < frames; f++) begin
      first = $urandom_range(0, n_obj - 1);
      for (int j = 0; j < n_obj; j++) begin
        k = (first + j) % n_obj;
        ox[k] = clamp_pos(ox[k] + vx[k]);
        oy[k] = clamp_pos(oy[k] + vy[k]);
        // occasional dropout makes the tracker forget the object
        if ($urandom_range(0, 99) >= 8) push_item(CMD_BLOB, ox[k], oy[k], kept_area());
        if ($urandom_range(0, 99) < 10)
          push_item(CMD_BLOB, $urandom_range(0, 65535), $urandom_range(0, 65535),
                    noise_area());
      end
      // frame end, sometimes with junk in the ignored fields
      if ($urandom_range(0, 1))
        push_item(CMD_FRAME_END, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  AREA_W'($urandom_range(0, AREA_MAX)));
      else
        push_item(CMD_FRAME_END, 0, 0, '0);
    end
  endtask

  // well separated blobs, more than the table holds, seen twice
  task automatic gen_crowd(int n);
    int cy[MAX_OBJ];
    for (int i = 0; i < n; i++) cy[i] = $urandom_range(0, 65535);
    for (int rep = 0; rep < 2; rep++) begin
      for (int i = 0; i < n; i++) push_item(CMD_BLOB, i * 950 + rep * 7, cy[i], kept_area());
      push_item(CMD_FRAME_END, 0, 0, '0);
    end
  endtask

  // wait until every item has gone in and every result has come back
  task automatic drain_results();
    @(negedge clk);
    while (pending_blobs.size() != 0 || predicted_results.size() != 0 || in_valid)
      @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // input driver: one transfer per accepted item, prediction at the transfer
  // --------------------------------------------------------------------------
  int         in_gap = 0;
  blob_item_t next_blob;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_results.insert(predicted_results.size(),
                                 track_blob(cmd, centroid_x, centroid_y, blob_area));
        in_gap = pick_gap(in_gaps_on);
      end
      // payload may only change once the current item is taken
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_blobs.size() != 0) begin
          next_blob = pending_blobs.pop_front();
          in_valid   <= 1'b1;
          cmd        <= next_blob.c;
          centroid_x <= next_blob.x;
          centroid_y <= next_blob.y;
          blob_area  <= next_blob.a;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output monitor with random back-pressure
  // --------------------------------------------------------------------------
  int out_stall = 0;

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        $error("result transfer with none outstanding, status %0d", status);
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          fail_count++;
        end
        if (object_id !== want.object_id) begin
          $error("object_id: expected %0d, actual %0d", want.object_id, object_id);
          fail_count++;
        end
        if (counted_now !== want.counted_now) begin
          $error("counted_now: expected %0d, actual %0d", want.counted_now, counted_now);
          fail_count++;
        end
        if (counted_area !== want.counted_area) begin
          $error("counted_area: expected %0d, actual %0d", want.counted_area, counted_area);
          fail_count++;
        end
        if (frame_area_total !== want.frame_area_total) begin
          $error("frame_area_total: expected %0d, actual %0d",
                 want.frame_area_total, frame_area_total);
          fail_count++;
        end
        if (frame_count !== want.frame_count) begin
          $error("frame_count: expected %0d, actual %0d", want.frame_count, frame_count);
          fail_count++;
        end
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall = pick_gap(out_stalls_on);
    end
  end

  // watchdog: too long without a transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("blob_centroid_tracker_counter verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned l;
    int unsigned r;
    int unsigned md;
    int unsigned t;
    int          xl;
    int          xh;
    // reset state of the mirror and the register shadow
    area_lo       = RST_MIN_AREA;
    area_hi       = RST_MAX_AREA;
    match_dist    = RST_MATCH_DISTANCE;
    edge_l        = RST_LEFT_EDGE_X;
    edge_r        = RST_RIGHT_EDGE_X;
    trk_next_id   = '0;
    trk_area_sum  = '0;
    trk_count_sum = '0;
    for (int i = 0; i < SLOTS; i++) begin
      trk_live[i]    = 1'b0;
      trk_seen[i]    = 1'b0;
      trk_id[i]      = '0;
      trk_x[i]       = '0;
      trk_y[i]       = '0;
      trk_counted[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values: zone is exactly x == 0
    push_item(CMD_FRAME_END, 0, 0, '0);           // empty frame
    push_item(CMD_BLOB, 100, 100, 24'd0);         // zero area
    push_item(CMD_BLOB, 100, 100, 24'd39);        // just below min
    push_item(CMD_BLOB, 0, 0, 24'd40);            // new, in zone, counted
    push_item(CMD_BLOB, 5000, 5000, 24'd40000);   // new at max area
    push_item(CMD_BLOB, 5000, 5000, 24'd40001);   // just above max
    push_item(CMD_BLOB, 5319, 5000, 24'd100);     // one short of the limit
    push_item(CMD_BLOB, 5639, 5000, 24'd100);     // exactly at the limit: new
    push_item(CMD_BLOB, 5479, 5000, 24'd100);     // equidistant: lower id wins
    push_item(CMD_FRAME_END, 0, 0, '0);
    push_item(CMD_BLOB, 0, 0, 24'd50);            // matched, already counted
    push_item(CMD_FRAME_END, 0, 0, '0);           // drops the unseen pair
    push_item(CMD_BLOB, 5479, 5000, 24'd100);     // reuses lowest free entry
    push_item(CMD_FRAME_END, 65535, 65535, 24'hFFFFFF);
    push_item(CMD_BLOB, 65535, 65535, 24'hFFFFFF);
    drain_results();

    // directed, widest window, largest distance, reversed zone
    load_config(0, AREA_MAX, 4095, 4095, 0);
    push_item(CMD_BLOB, 65535, 65535, 24'hFFFFFF);
    push_item(CMD_BLOB, 65535, 65535, 24'd0);
    push_item(CMD_BLOB, 65535 - 4094, 65535, 24'd1);
    push_item(CMD_BLOB, 65535 - 4095, 65535, 24'd1);
    push_item(CMD_FRAME_END, 0, 0, '0);
    drain_results();

    // objects crossing a narrow zone at reset-like settings
    load_config(40, 40000, 320, 100, 400);
    gen_frames(12, 5, 40, 2400, 5600);
    drain_results();

    // full field range, fast objects
    load_config(0, AREA_MAX, 4095, 0, 4095);
    gen_frames(8, 4, 1500, 0, 65535);
    drain_results();

    // zero distance: nothing ever matches, table fills up
    load_config(1, 1000, 0, 4095, 4095);
    gen_frames(3, 30, 10, 65400, 65535);
    drain_results();

    // single kept area, tiny zone
    load_config(AREA_MAX, AREA_MAX, 2000, 1000, 1003);
    gen_frames(5, 3, 20, 15900, 16200);
    drain_results();

    // crowds beyond the table size
    load_config(100, 5000, 600, 0, 3000);
    gen_crowd(66);
    drain_results();

    // empty window: only frame ends do anything
    load_config(AREA_MAX, 0, 12, 0, 0);
    gen_frames(1, 5, 10, 0, 65535);
    drain_results();

    // random settings until the budget is used
    while (sent_items < TARGET_ITEMS) begin
      l  = $urandom_range(0, 2000);
      r  = l + $urandom_range(0, 2000);
      if ($urandom_range(0, 5) == 0) begin
        t = l;
        l = r;
        r = t;
      end
      md = $urandom_range(16, 1200);
      load_config($urandom_range(0, 200), $urandom_range(1000, AREA_MAX), md, l, r);
      xl = int'(((l < r) ? l : r) * 16) - 3000;
      xh = int'(((l < r) ? r : l) * 16) + 3000;
      gen_frames($urandom_range(4, 12), $urandom_range(1, 8),
                 ($urandom_range(0, 4) == 0) ? 2 * md : md / 2,
                 clamp_pos(xl), clamp_pos(xh));
      drain_results();
    end

    // let any stray result show up before the verdict
    repeat (80) @(posedge clk);
    if (fail_count == 0 && predicted_results.size() == 0) begin
      $display("blob_centroid_tracker_counter verification clean");
    end else begin
      $display("blob_centroid_tracker_counter verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bct_pkg.sv
hw/rtl/bct_ram.sv
hw/rtl/blob_centroid_tracker_counter.sv
bench/blob_centroid_tracker_counter_tb.sv
